// ===== sv/score_sorted_move_list_macros.svh =====
// assertion macros used by the checker file
`ifndef SCORE_SORTED_MOVE_LIST_MACROS_SVH
`define SCORE_SORTED_MOVE_LIST_MACROS_SVH

// condition holds in the same cycle
`define SSML_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// condition holds in the next cycle
`define SSML_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== sv/ssml_pkg.sv =====
// package with types and codes of the score sorted move list
package ssml_pkg;

  localparam int MaxRecordsDef = 256;
  localparam int ScoreBitsDef  = 32;
  localparam int ScoreW        = 32;
  localparam int CoordW        = 4;

  localparam logic       KIND_LOAD = 1'b0;
  localparam logic       KIND_TAKE = 1'b1;

  localparam logic [1:0] ST_LOADED    = 2'd0;
  localparam logic [1:0] ST_DROPPED   = 2'd1;
  localparam logic [1:0] ST_DELIVERED = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic                     kind;
    logic [CoordW-1:0]        entry_row;
    logic [CoordW-1:0]        entry_col;
    logic signed [ScoreW-1:0] entry_score;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [CoordW-1:0]        out_row;
    logic [CoordW-1:0]        out_col;
    logic signed [ScoreW-1:0] out_score;
    logic                     is_final;
  } out_t;

  typedef struct packed {
    logic load;
    logic take;
  } cell_ctrl_t;

endpackage

// ===== sv/ssml_cell.sv =====
// one cell of the sorted chain: holds one record, compares and shifts
module ssml_cell #(
  parameter int SCORE_BITS = ssml_pkg::ScoreBitsDef
) (
  input  logic                             clk_i,
  input  ssml_pkg::cell_ctrl_t             ctrl_i,
  input  logic                             occ_i,
  input  logic [ssml_pkg::CoordW-1:0]      new_row_i,
  input  logic [ssml_pkg::CoordW-1:0]      new_col_i,
  input  logic signed [SCORE_BITS-1:0]     new_score_i,
  input  logic                             left_ge_i,
  input  logic [ssml_pkg::CoordW-1:0]      left_row_i,
  input  logic [ssml_pkg::CoordW-1:0]      left_col_i,
  input  logic signed [SCORE_BITS-1:0]     left_score_i,
  input  logic [ssml_pkg::CoordW-1:0]      right_row_i,
  input  logic [ssml_pkg::CoordW-1:0]      right_col_i,
  input  logic signed [SCORE_BITS-1:0]     right_score_i,
  output logic                             ge_o,
  output logic [ssml_pkg::CoordW-1:0]      row_o,
  output logic [ssml_pkg::CoordW-1:0]      col_o,
  output logic signed [SCORE_BITS-1:0]     score_o
);

  logic [ssml_pkg::CoordW-1:0]  row_q, row_d;
  logic [ssml_pkg::CoordW-1:0]  col_q, col_d;
  logic signed [SCORE_BITS-1:0] score_q, score_d;

  // new record goes ahead of every held record with an equal or lower score
  assign ge_o = !occ_i || (new_score_i >= score_q);

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    score_d = score_q;
    if (ctrl_i.load && ge_o) begin
      if (left_ge_i) begin
        row_d   = left_row_i;
        col_d   = left_col_i;
        score_d = left_score_i;
      end else begin
        row_d   = new_row_i;
        col_d   = new_col_i;
        score_d = new_score_i;
      end
    end else if (ctrl_i.take) begin
      row_d   = right_row_i;
      col_d   = right_col_i;
      score_d = right_score_i;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    col_q   <= col_d;
    score_q <= score_d;
  end

  assign row_o   = row_q;
  assign col_o   = col_q;
  assign score_o = score_q;

endmodule

// ===== sv/ssml_out_buf.sv =====
// two-entry output buffer that decouples input stall from output stall
module ssml_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ssml_pkg::out_t res_i,
  output logic           full_o,
  output logic           out_valid_o,
  output ssml_pkg::out_t out_data_o,
  input  logic           out_stall_i
);

  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;
  ssml_pkg::out_t out_q, out_d;
  ssml_pkg::out_t skid_q, skid_d;
  logic           pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/score_sorted_move_list.sv =====
// top level of the score sorted move list: insertion chain of cells
//
//   channel | direction | payload              | handshake
//   in      | input     | ssml_pkg::in_t       | in_valid_i / in_stall_o
//   out     | output    | ssml_pkg::out_t      | out_valid_o / out_stall_i
//
// one transaction per cycle unless the input stalls; a load or take completes in
// the cycle it is accepted, with every cell shifting or inserting in parallel, and
// its result is registered in the output buffer
// reset empties the list and the output buffer; cell contents are not cleared
// a stalled output fills the two-entry output buffer before the input stalls
module score_sorted_move_list #(
  parameter int MAX_RECORDS = ssml_pkg::MaxRecordsDef,
  parameter int SCORE_BITS  = ssml_pkg::ScoreBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ssml_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ssml_pkg::out_t out_data_o
);

  localparam int CntW = $clog2(MAX_RECORDS + 1);

  logic [CntW-1:0]              count_q, count_d;
  logic                         in_acc;
  logic                         full;
  logic                         empty;
  logic                         buf_full;
  ssml_pkg::cell_ctrl_t         ctrl;
  ssml_pkg::out_t               res;
  logic signed [SCORE_BITS-1:0] new_score;

  logic                             ge     [MAX_RECORDS];
  logic [ssml_pkg::CoordW-1:0]      c_row  [MAX_RECORDS];
  logic [ssml_pkg::CoordW-1:0]      c_col  [MAX_RECORDS];
  logic signed [SCORE_BITS-1:0]     c_score[MAX_RECORDS];

  assign in_acc    = in_valid_i && !buf_full;
  assign in_stall_o = buf_full;
  assign full      = (count_q == CntW'(MAX_RECORDS));
  assign empty     = (count_q == '0);
  assign new_score = in_data_i.entry_score[SCORE_BITS-1:0];

  assign ctrl.load = in_acc && (in_data_i.kind == ssml_pkg::KIND_LOAD) && !full;
  assign ctrl.take = in_acc && (in_data_i.kind == ssml_pkg::KIND_TAKE) && !empty;

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic                         occ;
    logic                         left_ge;
    logic [ssml_pkg::CoordW-1:0]  left_row, left_col, right_row, right_col;
    logic signed [SCORE_BITS-1:0] left_score, right_score;

    assign occ = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_ge    = 1'b0;
      assign left_row   = c_row[i];
      assign left_col   = c_col[i];
      assign left_score = c_score[i];
    end else begin : g_mid
      assign left_ge    = ge[i-1];
      assign left_row   = c_row[i-1];
      assign left_col   = c_col[i-1];
      assign left_score = c_score[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_last
      assign right_row   = c_row[i];
      assign right_col   = c_col[i];
      assign right_score = c_score[i];
    end else begin : g_inner
      assign right_row   = c_row[i+1];
      assign right_col   = c_col[i+1];
      assign right_score = c_score[i+1];
    end

    ssml_cell #(
      .SCORE_BITS(SCORE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ),
      .new_row_i    (in_data_i.entry_row),
      .new_col_i    (in_data_i.entry_col),
      .new_score_i  (new_score),
      .left_ge_i    (left_ge),
      .left_row_i   (left_row),
      .left_col_i   (left_col),
      .left_score_i (left_score),
      .right_row_i  (right_row),
      .right_col_i  (right_col),
      .right_score_i(right_score),
      .ge_o         (ge[i]),
      .row_o        (c_row[i]),
      .col_o        (c_col[i]),
      .score_o      (c_score[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.load) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.take) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_comb begin
    res = '0;
    if (in_data_i.kind == ssml_pkg::KIND_LOAD) begin
      res.status = full ? ssml_pkg::ST_DROPPED : ssml_pkg::ST_LOADED;
    end else if (empty) begin
      res.status = ssml_pkg::ST_EMPTY;
    end else begin
      res.status    = ssml_pkg::ST_DELIVERED;
      res.out_row   = c_row[0];
      res.out_col   = c_col[0];
      res.out_score = ssml_pkg::ScoreW'(c_score[0]);
      res.is_final  = (count_q == CntW'(1));
    end
  end

  ssml_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_acc),
    .res_i      (res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

endmodule

// ===== sv/ssml_checker.sv =====
// port-level checker of the score sorted move list and its bind
`include "score_sorted_move_list_macros.svh"

module ssml_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input ssml_pkg::out_t out_data_o
);

  logic out_held;

  assign out_held = out_valid_o && out_stall_i;

  `SSML_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_held, out_valid_o)
  `SSML_ASSERT_NEXT(a_out_data_holds, clk_i, rst_ni, out_held, $stable(out_data_o))
  `SSML_ASSERT_NOW(a_no_record_zero, clk_i, rst_ni,
    out_valid_o && (out_data_o.status != ssml_pkg::ST_DELIVERED),
    (out_data_o.out_row == '0) && (out_data_o.out_col == '0) &&
    (out_data_o.out_score == '0) && !out_data_o.is_final)
  `SSML_ASSERT_NOW(a_final_delivered, clk_i, rst_ni,
    out_valid_o && out_data_o.is_final,
    out_data_o.status == ssml_pkg::ST_DELIVERED)
  `SSML_ASSERT_NOW(a_stall_needs_output, clk_i, rst_ni, in_stall_o, out_valid_o)

endmodule

bind score_sorted_move_list ssml_checker u_ssml_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

// ===== tb/sv/tb_score_sorted_move_list.sv =====
// testbench for the score sorted move list: predictor, checker and test tasks
module tb_score_sorted_move_list;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxRecords    = ssml_pkg::MaxRecordsDef;
  localparam int ScoreBits     = ssml_pkg::ScoreBitsDef;
  localparam int ScoreW        = ssml_pkg::ScoreW;
  localparam int CoordW        = ssml_pkg::CoordW;
  localparam int RandomItems   = 1200;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 10;
  localparam int WatchdogLimit = 5000;
  localparam int ReportLimit   = 10;

  typedef enum int {SCORE_TIES, SCORE_FULL, SCORE_EDGE} score_mode_e;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  typedef struct packed {
    logic [CoordW-1:0]        row;
    logic [CoordW-1:0]        col;
    logic signed [ScoreW-1:0] score;
  } move_rec_t;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  ssml_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  ssml_pkg::out_t out_data;

  move_rec_t      held_moves[$];
  ssml_pkg::out_t pending_results[$];
  int             mismatches      = 0;
  int             burst_left      = 0;
  bit             no_gaps         = 1'b0;
  int             holds_requested = 0;
  int             holds_served    = 0;
  int             hold_left       = 0;
  int             mode_left       = 0;
  int             stall_phase     = 0;
  stall_mode_e    stall_mode      = STALL_NONE;
  int             idle_cycles     = 0;

  score_sorted_move_list u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #6 clk = ~clk;

  function automatic ssml_pkg::out_t sort_step(input ssml_pkg::in_t item);
    ssml_pkg::out_t res;
    move_rec_t      rec;
    int             best;
    res = '0;
    if (item.kind == ssml_pkg::KIND_LOAD) begin
      if (held_moves.size() >= MaxRecords) begin
        res.status = ssml_pkg::ST_DROPPED;
      end else begin
        rec.row   = item.entry_row;
        rec.col   = item.entry_col;
        rec.score = $signed(item.entry_score << (ScoreW - ScoreBits)) >>> (ScoreW - ScoreBits);
        held_moves.push_back(rec);
        res.status = ssml_pkg::ST_LOADED;
      end
    end else if (held_moves.size() == 0) begin
      res.status = ssml_pkg::ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < held_moves.size(); i++) begin
        if ($signed(held_moves[i].score) >= $signed(held_moves[best].score)) best = i;
      end
      res.status    = ssml_pkg::ST_DELIVERED;
      res.out_row   = held_moves[best].row;
      res.out_col   = held_moves[best].col;
      res.out_score = held_moves[best].score;
      held_moves.delete(best);
      res.is_final  = (held_moves.size() == 0);
    end
    return res;
  endfunction

  function automatic logic signed [ScoreW-1:0] rand_score(input score_mode_e mode);
    logic signed [ScoreW-1:0] s;
    case (mode)
      SCORE_TIES: s = int'($urandom_range(0, 6)) - 3;
      SCORE_FULL: s = $urandom();
      default: begin
        case ($urandom_range(0, 5))
          0: s = 32'sh8000_0000;
          1: s = 32'sh7fff_ffff;
          2: s = 32'sh8000_0001;
          3: s = 32'sh7fff_fffe;
          4: s = '0;
          default: s = '1;
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic ssml_pkg::in_t rand_item(input logic kind, input score_mode_e mode);
    ssml_pkg::in_t item;
    item.kind        = kind;
    item.entry_row   = CoordW'($urandom_range(0, 15));
    item.entry_col   = CoordW'($urandom_range(0, 15));
    item.entry_score = rand_score(mode);
    return item;
  endfunction

  function automatic ssml_pkg::in_t load_of(input int row, input int col,
                                            input logic signed [ScoreW-1:0] s);
    ssml_pkg::in_t item;
    item.kind        = ssml_pkg::KIND_LOAD;
    item.entry_row   = CoordW'(row);
    item.entry_col   = CoordW'(col);
    item.entry_score = s;
    return item;
  endfunction

  function automatic void check_field(input string name, input logic [ScoreW-1:0] want,
                                      input logic [ScoreW-1:0] got);
    if (got !== want) begin
      if (mismatches < ReportLimit) $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(input ssml_pkg::in_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(sort_step(item));
    if (!no_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 24);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 3);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(rand_item(ssml_pkg::KIND_TAKE, SCORE_FULL));
    send_item(load_of(0, 0, 32'sh8000_0000));
    send_item(load_of(15, 15, 32'sh7fff_ffff));
    send_item(load_of(5, 10, 0));
    send_item(load_of(10, 5, -1));
    send_item(load_of(1, 2, 7));
    send_item(load_of(3, 4, 7));
    send_item(load_of(6, 8, 7));
    send_item(load_of(9, 9, 32'sh7fff_ffff));
    send_item(load_of(15, 0, 32'sh8000_0000));
    repeat (10) send_item(rand_item(ssml_pkg::KIND_TAKE, SCORE_FULL));
    wait_drained();
  endtask

  task automatic test_full_store();
    int fill;
    fill = MaxRecords - held_moves.size();
    repeat (fill) send_item(rand_item(ssml_pkg::KIND_LOAD, score_mode_e'($urandom_range(0, 2))));
    repeat (3) send_item(rand_item(ssml_pkg::KIND_LOAD, SCORE_FULL));
    send_item(rand_item(ssml_pkg::KIND_TAKE, SCORE_FULL));
    send_item(rand_item(ssml_pkg::KIND_LOAD, SCORE_TIES));
    send_item(rand_item(ssml_pkg::KIND_LOAD, SCORE_EDGE));
    repeat (MaxRecords + 1) send_item(rand_item(ssml_pkg::KIND_TAKE, SCORE_FULL));
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    holds_requested++;
    no_gaps = 1'b1;
    repeat (40) send_item(rand_item(1'($urandom_range(0, 1)), SCORE_TIES));
    no_gaps = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_mix();
    int          sent;
    int          phase_len;
    int          load_pct;
    score_mode_e mode;
    sent = 0;
    while (sent < RandomItems) begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0: load_pct = 20;
        1: load_pct = 50;
        2: load_pct = 65;
        default: load_pct = 85;
      endcase
      mode = score_mode_e'($urandom_range(0, 2));
      repeat (phase_len) begin
        if (held_moves.size() > 160) load_pct = 25;
        if ($urandom_range(1, 100) <= load_pct) send_item(rand_item(ssml_pkg::KIND_LOAD, mode));
        else send_item(rand_item(ssml_pkg::KIND_TAKE, mode));
        sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (holds_served != holds_requested) begin
      holds_served = holds_requested;
      hold_left    = HoldCycles - 1;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      stall_phase++;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (stall_phase % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    ssml_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (mismatches < ReportLimit) $display("unexpected transaction: got %0h", out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", ScoreW'(want.status), ScoreW'(out_data.status));
        check_field("out_row", ScoreW'(want.out_row), ScoreW'(out_data.out_row));
        check_field("out_col", ScoreW'(want.out_col), ScoreW'(out_data.out_col));
        check_field("out_score", want.out_score, out_data.out_score);
        check_field("is_final", ScoreW'(want.is_final), ScoreW'(out_data.is_final));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("score_sorted_move_list verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_output_backpressure();
    test_random_mix();
    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("score_sorted_move_list verification clean");
    end else begin
      $display("score_sorted_move_list verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ssml_pkg.sv
sv/ssml_cell.sv
sv/ssml_out_buf.sv
sv/score_sorted_move_list.sv
sv/ssml_checker.sv
tb/sv/tb_score_sorted_move_list.sv
